// ===== rtl/core/lid_pkg.sv =====
`timescale 1ns / 1ps
// Package for the piecewise linear interpolator: sizes, codes, pipeline control type.
// No dependencies.
package lid_pkg;

  localparam int NPTS       = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int DW         = 32;
  localparam int DIV_STEPS  = 32;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 32;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_EVAL  = 1'b1;

  localparam logic [1:0] REG_BELOW  = 2'd0;
  localparam logic [1:0] REG_INTERP = 2'd1;
  localparam logic [1:0] REG_ABOVE  = 2'd2;

  typedef struct packed {
    logic [1:0]    region;
    logic          neg;
    logic [DW-1:0] y_base;
  } ctl_t;

endpackage

// ===== rtl/core/lid_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, carrying control alongside.
// Depends on lid_pkg.
module lid_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  lid_pkg::ctl_t            in_ctl,
  input  logic [2*lid_pkg::DW-1:0] dividend,
  input  logic [lid_pkg::DW-1:0]   divisor,
  output logic                     out_vld,
  output lid_pkg::ctl_t            out_ctl,
  output logic [lid_pkg::DW-1:0]   quotient
);

  localparam int N = lid_pkg::DIV_STEPS;
  localparam int W = lid_pkg::DW;

  logic          vld_r [0:N];
  lid_pkg::ctl_t ctl_r [0:N];
  logic [W-1:0]  rem_r [0:N];
  logic [W-1:0]  lo_r  [0:N];
  logic [W-1:0]  quo_r [0:N];
  logic [W-1:0]  dx_r  [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
    if (en) begin
      ctl_r[0] <= in_ctl;
      rem_r[0] <= dividend[2*W-1:W];
      lo_r[0]  <= dividend[W-1:0];
      quo_r[0] <= '0;
      dx_r[0]  <= divisor;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    assign trial = {rem_r[s], lo_r[s][W-1]};
    assign diff  = trial - {1'b0, dx_r[s]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (en) begin
        ctl_r[s+1] <= ctl_r[s];
        dx_r[s+1]  <= dx_r[s];
        lo_r[s+1]  <= {lo_r[s][W-2:0], 1'b0};
        if (!diff[W]) begin
          rem_r[s+1] <= diff[W-1:0];
          quo_r[s+1] <= {quo_r[s][W-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= trial[W-1:0];
          quo_r[s+1] <= {quo_r[s][W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_ctl  = ctl_r[N];
  assign quotient = quo_r[N];

endmodule

// ===== rtl/core/linear_interp_flat_extrap.sv =====
`timescale 1ns / 1ps
// Piecewise linear interpolation with flat extrapolation over a 16-entry breakpoint table.
// An evaluate transfer passes stages 0 to 3, the 32-stage divider pipeline and the output register;
// one item per cycle while out_tready does not stall; stalls on out_tready freeze all stages.
// Write items update the table at their transfer and produce no result.
// Synchronous active-low reset empties the pipeline and sets point_count to 1.
// Depends on lid_pkg and lid_div.
module linear_interp_flat_extrap (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lid_pkg::CNT_W-1:0]         cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // point_index[3:0], point_x[35:4], point_y[67:36], query_x[99:68], zero pad
  input  logic [lid_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // result_y[31:0]
  output logic [lid_pkg::OUT_DATA_W-1:0]    out_tdata,
  // region[1:0]
  output logic [1:0]                        out_tuser
);

  localparam int N  = lid_pkg::NPTS;
  localparam int W  = lid_pkg::DW;
  localparam int IW = lid_pkg::IDX_W;

  logic                       en;
  logic                       acc;
  logic [lid_pkg::CNT_W-1:0]  cnt_r;
  logic [lid_pkg::CNT_W-1:0]  used;
  logic signed [W-1:0]        x_tab [0:N-1];
  logic [W-1:0]               y_tab [0:N-1];
  logic [IW-1:0]              pidx;
  logic signed [W-1:0]        px, qx;
  logic [W-1:0]               py;

  assign pidx = in_tdata[IW-1:0];
  assign px   = in_tdata[IW+W-1:IW];
  assign py   = in_tdata[IW+2*W-1:IW+W];
  assign qx   = in_tdata[IW+3*W-1:IW+2*W];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= lid_pkg::CNT_W'(1);
    end else if (cfg_valid) begin
      cnt_r <= cfg_data;
    end
  end

  always_comb begin
    used = cnt_r;
    if (cnt_r == '0) used = lid_pkg::CNT_W'(1);
    if (cnt_r > lid_pkg::CNT_W'(N)) used = lid_pkg::CNT_W'(N);
  end

  always_ff @(posedge clk) begin
    if (acc && in_tuser == lid_pkg::OP_WRITE) begin
      x_tab[pidx] <= px;
      y_tab[pidx] <= py;
    end
  end

  // Stage 0: comparator array
  logic                 s0_vld_r;
  logic [N-1:0]         s0_ge_r, ge_nxt;
  logic [N-1:0]         s0_last_r, last_nxt;
  logic signed [W-1:0]  s0_q_r;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ge_nxt[i]   = (x_tab[i] >= qx) && (lid_pkg::CNT_W'(i) < used);
      last_nxt[i] = (lid_pkg::CNT_W'(i + 1) == used);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= acc && in_tuser == lid_pkg::OP_EVAL;
    end
    if (en) begin
      s0_ge_r   <= ge_nxt;
      s0_last_r <= last_nxt;
      s0_q_r    <= qx;
    end
  end

  // Stage 1: first qualifying entry, operand fetch
  logic                 s1_vld_r;
  logic [1:0]           s1_reg_r, reg_nxt;
  logic signed [W-1:0]  s1_xl_r, s1_xr_r, s1_yl_r, s1_yr_r, s1_q_r;
  logic signed [W-1:0]  xl_nxt, xr_nxt, yl_nxt, yr_nxt;
  logic [N-1:0]         first;
  logic                 seen;

  always_comb begin
    seen   = 1'b0;
    xl_nxt = '0;
    xr_nxt = '0;
    yl_nxt = '0;
    yr_nxt = '0;
    for (int i = 0; i < N; i++) begin
      first[i] = s0_ge_r[i] && !seen;
      seen     = seen || s0_ge_r[i];
    end
    for (int i = 0; i < N; i++) begin
      if (first[i]) begin
        xr_nxt = xr_nxt | x_tab[i];
        yr_nxt = yr_nxt | y_tab[i];
      end
      if (i + 1 < N && first[(i + 1) % N]) begin
        xl_nxt = xl_nxt | x_tab[i];
        yl_nxt = yl_nxt | y_tab[i];
      end
    end
    if (s0_ge_r[0]) begin
      reg_nxt = lid_pkg::REG_BELOW;
      yl_nxt  = y_tab[0];
    end else if (!seen) begin
      reg_nxt = lid_pkg::REG_ABOVE;
      yl_nxt  = '0;
      for (int i = 0; i < N; i++) begin
        if (s0_last_r[i]) yl_nxt = yl_nxt | y_tab[i];
      end
    end else begin
      reg_nxt = lid_pkg::REG_INTERP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
    if (en) begin
      s1_reg_r <= reg_nxt;
      s1_xl_r  <= xl_nxt;
      s1_xr_r  <= xr_nxt;
      s1_yl_r  <= yl_nxt;
      s1_yr_r  <= yr_nxt;
      s1_q_r   <= s0_q_r;
    end
  end

  // Stage 2: differences
  logic          s2_vld_r;
  lid_pkg::ctl_t s2_ctl_r;
  logic [W-1:0]  s2_dq_r, s2_dx_r, s2_mag_r;
  logic          neg_nxt;

  assign neg_nxt = s1_yr_r < s1_yl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
    if (en) begin
      s2_ctl_r.region <= s1_reg_r;
      s2_ctl_r.neg    <= neg_nxt;
      s2_ctl_r.y_base <= s1_yl_r;
      s2_dq_r         <= W'(s1_q_r - s1_xl_r);
      s2_dx_r         <= W'(s1_xr_r - s1_xl_r);
      s2_mag_r        <= neg_nxt ? W'(s1_yl_r - s1_yr_r) : W'(s1_yr_r - s1_yl_r);
    end
  end

  // Stage 3: product
  logic          s3_vld_r;
  lid_pkg::ctl_t s3_ctl_r;
  logic [2*W-1:0] s3_prod_r;
  logic [W-1:0]  s3_dx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
    if (en) begin
      s3_ctl_r  <= s2_ctl_r;
      s3_prod_r <= s2_dq_r * s2_mag_r;
      s3_dx_r   <= s2_dx_r;
    end
  end

  logic          dv_vld;
  lid_pkg::ctl_t dv_ctl;
  logic [W-1:0]  dv_quo;

  lid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s3_vld_r),
    .in_ctl   (s3_ctl_r),
    .dividend (s3_prod_r),
    .divisor  (s3_dx_r),
    .out_vld  (dv_vld),
    .out_ctl  (dv_ctl),
    .quotient (dv_quo)
  );

  // Output register
  logic          out_vld_r;
  logic [W-1:0]  out_y_r, y_nxt;
  logic [1:0]    out_reg_r;

  always_comb begin
    if (dv_ctl.region != lid_pkg::REG_INTERP) begin
      y_nxt = dv_ctl.y_base;
    end else if (dv_ctl.neg) begin
      y_nxt = dv_ctl.y_base - dv_quo;
    end else begin
      y_nxt = dv_ctl.y_base + dv_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
    if (en) begin
      out_y_r   <= y_nxt;
      out_reg_r <= dv_ctl.region;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_y_r;
  assign out_tuser  = out_reg_r;

endmodule

// ===== rtl/core/lid_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for linear_interp_flat_extrap, attached by bind.
// Depends on lid_pkg.
module lid_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [lid_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == lid_pkg::REG_BELOW || out_tuser == lid_pkg::REG_INTERP ||
                   out_tuser == lid_pkg::REG_ABOVE)
    else $error("bad region code");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

endmodule

bind linear_interp_flat_extrap lid_checker u_lid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/linear_interp_flat_extrap_checker.sv =====
`timescale 1ns / 1ps
// Checker for linear_interp_flat_extrap: tracks the breakpoint table and point count from
// observed transfers, predicts each evaluate result and compares out transfers in order.
// Depends on lid_pkg.
module linear_interp_flat_extrap_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lid_pkg::CNT_W-1:0]      cfg_data,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [lid_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [lid_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]                     out_tuser,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic [lid_pkg::DW-1:0] y;
    logic [1:0]             region;
  } curve_val_t;

  logic signed [lid_pkg::DW-1:0] x_tab [lid_pkg::NPTS];
  logic signed [lid_pkg::DW-1:0] y_tab [lid_pkg::NPTS];
  logic [lid_pkg::CNT_W-1:0]     point_count;
  curve_val_t                    curve_q [$];

  assign pending = curve_q.size();

  initial fail_count = 0;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic curve_val_t eval_curve(input logic signed [lid_pkg::DW-1:0] q);
    int          n;
    int          k;
    longint      xl;
    longint      yl;
    longint      yr;
    logic [63:0] dq;
    logic [63:0] dx;
    logic [63:0] mag;
    logic [63:0] quot;
    longint      res;
    curve_val_t  r;
    n = (point_count == 0) ? 1 :
        (point_count > lid_pkg::NPTS) ? lid_pkg::NPTS : int'(point_count);
    k = n;
    for (int i = n - 1; i >= 0; i--)
      if (x_tab[i] >= q) k = i;
    if (k == 0) begin
      r.y = y_tab[0];
      r.region = lid_pkg::REG_BELOW;
    end else if (k == n) begin
      r.y = y_tab[n-1];
      r.region = lid_pkg::REG_ABOVE;
    end else begin
      xl = longint'(x_tab[k-1]);
      yl = longint'(y_tab[k-1]);
      yr = longint'(y_tab[k]);
      dq = 64'(longint'(q) - xl);
      dx = 64'(longint'(x_tab[k]) - xl);
      mag = (yr < yl) ? 64'(yl - yr) : 64'(yr - yl);
      quot = (dq * mag) / dx;
      res = (yr < yl) ? yl - longint'(quot) : yl + longint'(quot);
      r.y = res[lid_pkg::DW-1:0];
      r.region = lid_pkg::REG_INTERP;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    curve_val_t want;
    if (!rst_n) begin
      point_count <= lid_pkg::CNT_W'(1);
      for (int i = 0; i < lid_pkg::NPTS; i++) begin
        x_tab[i] <= '0;
        y_tab[i] <= '0;
      end
      curve_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) point_count <= cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == lid_pkg::OP_WRITE) begin
          x_tab[in_tdata[3:0]] <= in_tdata[35:4];
          y_tab[in_tdata[3:0]] <= in_tdata[67:36];
        end else begin
          curve_q.push_back(eval_curve(in_tdata[99:68]));
        end
      end
      if (out_tvalid && out_tready) begin
        if (curve_q.size() == 0) begin
          report($sformatf("unexpected result y=%h region=%0d", out_tdata, out_tuser));
        end else begin
          want = curve_q.pop_front();
          if (out_tdata !== want.y)
            report($sformatf("result_y %h, expected %h", out_tdata, want.y));
          if (out_tuser !== want.region)
            report($sformatf("region %0d, expected %0d", out_tuser, want.region));
        end
      end
    end
  end

endmodule

// ===== tb/linear_interp_flat_extrap_test.sv =====
`timescale 1ns / 1ps
// Testbench top for linear_interp_flat_extrap: table loads, point count changes, directed and
// random queries with bursty input and stalling output. Depends on lid_pkg and the checker.
module linear_interp_flat_extrap_test;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [lid_pkg::CNT_W-1:0]      cfg_data = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [lid_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lid_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                     out_tuser;
  int                             fail_count;
  int                             pending;
  int                             burst_left = 0;
  int                             stall_mode = 0;
  int                             stall_cnt = 0;
  int                             bp_x [lid_pkg::NPTS];

  always #5 clk = ~clk;

  linear_interp_flat_extrap i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  linear_interp_flat_extrap_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fail_count(fail_count), .pending(pending)
  );

  // receiver: free-running, random, or heavily stalled, re-chosen whenever stall_cnt wraps to zero
  always @(negedge clk) begin
    if (stall_cnt == 0) stall_mode <= $urandom_range(0, 2);
    stall_cnt <= (stall_cnt + 1) % 64;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send(input logic op, input logic [lid_pkg::IDX_W-1:0] idx,
                      input logic [lid_pkg::DW-1:0] px, input logic [lid_pkg::DW-1:0] py,
                      input logic [lid_pkg::DW-1:0] qx);
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {4'b0, qx, py, px, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_point(input int idx, input int px, input int py);
    send(lid_pkg::OP_WRITE, idx[lid_pkg::IDX_W-1:0], px, py, $urandom);
  endtask

  task automatic eval_at(input int q);
    send(lid_pkg::OP_EVAL, lid_pkg::IDX_W'($urandom), $urandom, $urandom, q);
  endtask

  task automatic set_count(input int cnt);
    @(negedge clk);
    in_tvalid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (45) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = cnt[lid_pkg::CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // loads all entries; style 0 full-range sorted, 1 clustered sorted with repeats, 2 unsorted
  task automatic load_table(input int style);
    int base;
    if (style == 1) base = $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
    for (int i = 0; i < lid_pkg::NPTS; i++) begin
      case (style)
        0: bp_x[i] = $urandom;
        1: begin
          bp_x[i] = base;
          base += ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 1 << $urandom_range(0, 20));
        end
        default: bp_x[i] = $urandom;
      endcase
    end
    if (style == 0) bp_x.sort();
    for (int i = 0; i < lid_pkg::NPTS; i++)
      write_point(i, bp_x[i], ($urandom_range(0, 7) == 0) ?
                  (($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000) : $urandom);
  endtask

  function automatic int pick_query();
    int k;
    k = $urandom_range(0, lid_pkg::NPTS - 1);
    case ($urandom_range(0, 5))
      0: return bp_x[k];
      1: return bp_x[k] + 1;
      2: return bp_x[k] - 1;
      3: return bp_x[k] + int'($urandom_range(0, 1 << 16)) - (1 << 15);
      4: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("FAIL linear_interp_flat_extrap");
    $finish;
  end

  initial begin
    int cnt;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extreme breakpoints, then single point, zero and oversized counts
    for (int i = 0; i < lid_pkg::NPTS; i++) bp_x[i] = (i - 8) << 20;
    bp_x[0] = 32'h8000_0000;
    bp_x[lid_pkg::NPTS-1] = 32'h7fff_ffff;
    for (int i = 0; i < lid_pkg::NPTS; i++)
      write_point(i, bp_x[i], (i % 2 == 0) ? 32'h7fff_ffff : 32'h8000_0000);
    set_count(16);
    eval_at(32'h8000_0000);
    eval_at(32'h7fff_ffff);
    eval_at(32'h7fff_fffe);
    eval_at(32'h8000_0001);
    eval_at(0);
    set_count(1);
    eval_at(32'h8000_0000);
    eval_at(5);
    set_count(0);
    eval_at(32'h7fff_ffff);
    set_count(31);
    eval_at(32'h7fff_ffff);
    eval_at(7 << 20);

    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: cnt = 16;
        1: cnt = 1;
        2: cnt = 2;
        3: cnt = 0;
        4: cnt = 31;
        default: cnt = $urandom_range(0, 31);
      endcase
      set_count(cnt);
      load_table(phase % 3);
      for (int n = 0; n < 85; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          bp_x[n % lid_pkg::NPTS] = $urandom;
          write_point(n % lid_pkg::NPTS, bp_x[n % lid_pkg::NPTS], $urandom);
        end else begin
          eval_at(pick_query());
        end
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS linear_interp_flat_extrap");
    end else begin
      $display("FAIL linear_interp_flat_extrap");
    end
    $finish;
  end

endmodule
